// ===== src/binary_heap_priority_queue_core_assert.svh =====
// Assertion macros for the heap priority queue core.
// Used by the controller; needs nothing else.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define BHPQ_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("bhpq assertion failed");

// next-cycle implication
`define BHPQ_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("bhpq assertion failed");

`endif

// ===== src/bhpq_pkg.sv =====
// Shared types, constants and helpers of the heap priority queue core.
// No dependencies.
`default_nettype none

package bhpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ADDR_W     = $clog2(CAPACITY);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      pos_t;
    typedef logic [CNT_W:0]        child_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [1:0]            status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic  operation;
        data_t data_value;
    } req_word_t;

    typedef struct packed {
        data_t   removed_value;
        status_t status;
        logic    is_empty;
        pos_t    entry_count;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_REM_LOAD,
        ST_DN_FETCH,
        ST_DN_CMP,
        ST_FIN
    } ctl_state_t;

    typedef struct packed {
        logic take;
        logic ins_step;
        logic ins_put;
        logic rem_load;
        logic dn_fetch;
        logic dn_step;
        logic out_load;
    } bhpq_cmd_t;

    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
        logic ins_up;
        logic parent_root;
        logic dn_leaf;
        logic dn_move;
    } bhpq_sts_t;

    function automatic logic outranks(input logic mode, input data_t a, input data_t b);
        return mode ? (a > b) : (a < b);
    endfunction

    function automatic addr_t pos_addr(input pos_t p);
        pos_t t;
        t = p - pos_t'(1);
        return t[ADDR_W-1:0];
    endfunction

    function automatic addr_t child_addr(input child_t c);
        child_t t;
        t = c - child_t'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/binary_heap_priority_queue_core.sv =====
// Insert sifts up with one RAM compare-and-move per level; removal sifts down with a fetch
// and a compare per level; a refused item goes straight to the result.
// Throughput: one item at a time, next item taken the cycle after its result is loaded.
// Reset: asynchronous, clears count, order register and result valid; heap RAM not cleared.
// Top level of the heap priority queue core; depends on bhpq_pkg, bhpq_ctrl, bhpq_datapath.
`default_nettype none

module binary_heap_priority_queue_core
    import bhpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);

    bhpq_cmd_t cmd;
    bhpq_sts_t sts;

    bhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bhpq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_word    (req_word),
        .cmd         (cmd),
        .sts         (sts),
        .rsp_word    (rsp_word)
    );

endmodule

`default_nettype wire

// ===== src/bhpq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== src/bhpq_datapath.sv =====
// Datapath: heap store, count, order register, sift position and result word.
// Depends on bhpq_pkg and bhpq_ram.
`default_nettype none

module bhpq_datapath
    import bhpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire req_word_t req_word,
    input  wire bhpq_cmd_t cmd,
    output bhpq_sts_t      sts,
    output rsp_word_t      rsp_word
);

    pos_t      pos_reg,    pos_next;
    data_t     val_reg,    val_next;
    data_t     top_reg,    top_next;
    status_t   status_reg, status_next;
    pos_t      count_reg,  count_next;
    logic      order_reg;
    rsp_word_t rsp_reg,    rsp_next;

    logic  wr_en;
    addr_t wr_addr;
    data_t wr_data;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    data_t rd_data_a;
    data_t rd_data_b;

    pos_t   ins_pos;
    child_t left;
    child_t right;
    child_t count_ext;
    logic   right_ok;
    logic   pick_right;
    data_t  pick_val;
    pos_t   pick_pos;

    bhpq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign ins_pos    = count_reg + pos_t'(1);
    assign left       = {pos_reg, 1'b0};
    assign right      = left | child_t'(1);
    assign count_ext  = {1'b0, count_reg};
    assign right_ok   = right <= count_ext;
    assign pick_right = right_ok && outranks(order_reg, rd_data_b, rd_data_a);
    assign pick_val   = pick_right ? rd_data_b : rd_data_a;
    assign pick_pos   = pick_right ? right[CNT_W-1:0] : left[CNT_W-1:0];

    always_comb
    begin
        sts.op_remove   = req_word.operation == OP_REMOVE;
        sts.full        = count_reg == pos_t'(CAPACITY);
        sts.empty       = count_reg == '0;
        sts.ins_up      = outranks(order_reg, val_reg, rd_data_a);
        sts.parent_root = (pos_reg >> 1) == pos_t'(1);
        sts.dn_leaf     = left > count_ext;
        sts.dn_move     = outranks(order_reg, pick_val, val_reg);
    end

    always_comb
    begin
        pos_next    = pos_reg;
        val_next    = val_reg;
        top_next    = top_reg;
        status_next = status_reg;
        count_next  = count_reg;
        rsp_next    = rsp_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_addr(pos_reg);
        wr_data     = val_reg;
        rd_addr_a   = pos_addr(pos_reg);
        rd_addr_b   = pos_addr(count_reg);

        if (cmd.take)
        begin
            pos_next = ins_pos;
            val_next = req_word.data_value;
            top_next = '0;
            if (req_word.operation == OP_INSERT)
            begin
                status_next = sts.full ? STATUS_FULL : STATUS_DONE;
                rd_addr_a   = pos_addr(ins_pos >> 1);
            end
            else
            begin
                status_next = sts.empty ? STATUS_EMPTY : STATUS_DONE;
                rd_addr_a   = pos_addr(pos_t'(1));
            end
        end

        if (cmd.ins_step)
        begin
            wr_en = 1'b1;
            if (sts.ins_up)
            begin
                wr_data   = rd_data_a;
                pos_next  = pos_reg >> 1;
                rd_addr_a = pos_addr(pos_reg >> 2);
            end
            else
            begin
                count_next = ins_pos;
            end
        end

        if (cmd.ins_put)
        begin
            wr_en      = 1'b1;
            count_next = ins_pos;
        end

        if (cmd.rem_load)
        begin
            top_next   = rd_data_a;
            val_next   = rd_data_b;
            count_next = count_reg - pos_t'(1);
            pos_next   = pos_t'(1);
        end

        if (cmd.dn_fetch)
        begin
            rd_addr_a = child_addr(left);
            rd_addr_b = child_addr(right);
            wr_en     = sts.dn_leaf && !sts.empty;
        end

        if (cmd.dn_step)
        begin
            wr_en = 1'b1;
            if (sts.dn_move)
            begin
                wr_data  = pick_val;
                pos_next = pick_pos;
            end
        end

        if (cmd.out_load)
        begin
            rsp_next.removed_value = top_reg;
            rsp_next.status        = status_reg;
            rsp_next.is_empty      = sts.empty;
            rsp_next.entry_count   = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            order_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                order_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        top_reg    <= top_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_word = rsp_reg;

endmodule

`default_nettype wire

// ===== src/bhpq_ctrl.sv =====
// Controller: sequences insert sift-up, removal sift-down and result hand-off.
// Depends on bhpq_pkg and the assertion macro header.
`default_nettype none
`include "binary_heap_priority_queue_core_assert.svh"

module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    input  wire bhpq_sts_t sts,
    output bhpq_cmd_t      cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && rsp_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take = 1'b1;
                    if (!sts.op_remove)
                    begin
                        if (sts.full)
                        begin
                            state_next = ST_FIN;
                        end
                        else if (sts.empty)
                        begin
                            state_next = ST_INS_PUT;
                        end
                        else
                        begin
                            state_next = ST_INS_CMP;
                        end
                    end
                    else
                    begin
                        state_next = sts.empty ? ST_FIN : ST_REM_LOAD;
                    end
                end
            end
            ST_INS_CMP:
            begin
                cmd.ins_step = 1'b1;
                if (!sts.ins_up)
                begin
                    state_next = ST_FIN;
                end
                else if (sts.parent_root)
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:
            begin
                cmd.ins_put = 1'b1;
                state_next  = ST_FIN;
            end
            ST_REM_LOAD:
            begin
                cmd.rem_load = 1'b1;
                state_next   = ST_DN_FETCH;
            end
            ST_DN_FETCH:
            begin
                cmd.dn_fetch = 1'b1;
                state_next   = sts.dn_leaf ? ST_FIN : ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                cmd.dn_step = 1'b1;
                state_next  = sts.dn_move ? ST_DN_FETCH : ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = out_valid_reg;

    `BHPQ_ASSERT_IMP(a_cmd_single, clk, rst_n, 1'b1, $onehot0(cmd))
    `BHPQ_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || !rsp_stall)
    `BHPQ_ASSERT_IMP(a_rsp_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FIN)
    `BHPQ_ASSERT_NEXT(a_take_leaves_idle, clk, rst_n, cmd.take, state_reg != ST_IDLE)

endmodule

`default_nettype wire
